@@ hdl/aspi_pkg.sv @@
// Shared types, constants and helpers for the accelerometer SPI poll sequencer.
// Depends on nothing; every other file in hdl/ imports it.
package aspi_pkg;

	// Sequencer constants
	localparam int          DIAG_EVERY = 8;
	localparam int          NUM_AXES   = 3;
	localparam int          DIAG_W     = 8;
	localparam int          AXIS_W     = 2;
	localparam int          TICK_W     = 16;
	localparam int          APB_AW     = 3;

	localparam logic [7:0]        CTRL_ADDR   = 8'h20;
	localparam logic [7:0]        CTRL_VALUE  = 8'h47;
	localparam logic [7:0]        READ_BIT    = 8'h80;
	localparam logic [7:0]        NO_BYTE     = 8'h00;
	localparam logic [TICK_W-1:0] TICK_MAX    = '1;
	localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd100;
	localparam logic [DIAG_W-1:0] DIAG_LAST   = DIAG_W'(DIAG_EVERY - 1);
	localparam logic [AXIS_W-1:0] AXIS_LIMIT  = AXIS_W'(NUM_AXES);
	localparam logic [AXIS_W-1:0] AXIS_UNUSED = 2'd3;

	// Register index of the configuration port
	localparam logic REG_TIMEOUT = 1'b0;

	// Bring-up progress
	typedef enum logic [1:0] {
		PH_IDLE          = 2'd0,
		PH_WRITE_SENT    = 2'd1,
		PH_READBACK_SENT = 2'd2,
		PH_CHECKED       = 2'd3
	} phase_t;

	// One handler tick
	typedef struct packed {
		logic       spi_done;
		logic [7:0] rx_byte;
	} tick_t;

	// One result item
	typedef struct packed {
		logic              spi_start;
		logic [7:0]        spi_first_byte;
		logic [7:0]        spi_second_byte;
		logic              cs_release;
		logic              sample_valid;
		logic [AXIS_W-1:0] sample_axis;
		logic [7:0]        sample_value;
		logic              error_flag;
		logic              ready_res;
	} result_t;

	// Sequencer state carried from tick to tick
	typedef struct packed {
		phase_t            phase;
		logic              fault;
		logic              in_read;
		logic              got_reply;
		logic [DIAG_W-1:0] diag_count;
		logic [AXIS_W-1:0] axis_pos;
		logic [TICK_W-1:0] tick_count;
		logic              done_pending;
		logic [7:0]        rx_hold;
	} seq_state_t;

	// Data register address of an axis
	function automatic logic [7:0] axis_addr(input logic [AXIS_W-1:0] axis);
		logic [7:0] addr;
		unique case (axis)
			2'd0:    addr = 8'h29;
			2'd1:    addr = 8'h2b;
			2'd2:    addr = 8'h2d;
			default: addr = 8'h29;
		endcase
		return addr;
	endfunction

endpackage

@@ hdl/accel_spi_poll_sequencer.sv @@
// Top level of the accelerometer SPI poll sequencer: tick input register,
// state registers, result register and APB configuration. Uses aspi_pkg, aspi_step.
//
//   channel  | signals                                   | moves
//   ---------+-------------------------------------------+------------------------
//   tick     | tick_valid, tick_ready, tick              | one handler tick item
//   result   | result_valid, result_ready, result        | one result item
//   apb      | psel, penable, pwrite, paddr, pwdata, ... | timeout_period register
//
// One item per cycle sustained while the result side is not stalled; each item passes
// through the tick register and then the result register on its way to the result.
// Reset clears the sequencer state and sets timeout_period to 100.
// A stalled result holds the tick register, which then holds the input.
module accel_spi_poll_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_valid,
	output logic                          tick_ready,
	input  aspi_pkg::tick_t               tick,
	output logic                          result_valid,
	input  logic                          result_ready,
	output aspi_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [aspi_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import aspi_pkg::*;

	logic              valid_s1;
	tick_t             tick_s1;
	logic              valid_s2;
	result_t           result_s2;
	seq_state_t        state_q;
	seq_state_t        state_nxt;
	result_t           step_result;
	logic [TICK_W-1:0] timeout_q;
	logic              advance;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT)) begin
			timeout_q <= pwdata[TICK_W-1:0];
		end
	end

	// Advance the tick register into the result register
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign tick_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_ready && tick_valid) begin
			tick_s1 <= tick;
		end
	end

	aspi_step u_step (
		.cur            (state_q),
		.tick           (tick_s1),
		.timeout_period (timeout_q),
		.nxt            (state_nxt),
		.result         (step_result)
	);

	// Commit the state once per processed item; all zero is the idle phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= step_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

@@ hdl/aspi_step.sv @@
// Per-tick transition logic of the poll sequencer: next state and result item.
// Depends on aspi_pkg for the state, tick and result types.
module aspi_step (
	input  aspi_pkg::seq_state_t             cur,
	input  aspi_pkg::tick_t                  tick,
	input  logic [aspi_pkg::TICK_W-1:0]      timeout_period,
	output aspi_pkg::seq_state_t             nxt,
	output aspi_pkg::result_t                result
);
	import aspi_pkg::*;

	logic              dp;
	logic [7:0]        rx;
	logic              running;
	logic              read_busy;
	logic              is_diag;
	logic              consume;
	logic [TICK_W-1:0] tick_inc;
	logic              window_end;
	logic              launch;
	logic [AXIS_W-1:0] axis_inc;

	// Latch the completion before the tick is processed
	assign dp = cur.done_pending | tick.spi_done;
	assign rx = tick.spi_done ? tick.rx_byte : cur.rx_hold;

	assign running    = (cur.phase == PH_CHECKED) && !cur.fault;
	assign read_busy  = running && cur.in_read;
	assign is_diag    = (cur.diag_count == DIAG_LAST);
	assign consume    = dp && ((cur.phase == PH_WRITE_SENT) ||
		(cur.phase == PH_READBACK_SENT) || read_busy);
	assign tick_inc   = (cur.tick_count == TICK_MAX) ? cur.tick_count
		: cur.tick_count + 1'b1;
	assign window_end = (tick_inc >= timeout_period);
	assign launch     = (cur.phase == PH_IDLE) || ((cur.phase == PH_WRITE_SENT) && dp) ||
		(running && !cur.in_read);
	assign axis_inc   = cur.axis_pos + 1'b1;

	// Next state
	always_comb begin
		nxt              = cur;
		nxt.rx_hold      = rx;
		nxt.done_pending = consume ? 1'b0 : dp;
		unique case (cur.phase)
			PH_IDLE: begin
				nxt.phase = PH_WRITE_SENT;
			end
			PH_WRITE_SENT: begin
				if (dp) begin
					nxt.phase = PH_READBACK_SENT;
				end
			end
			PH_READBACK_SENT: begin
				if (dp) begin
					nxt.phase = PH_CHECKED;
					nxt.fault = (rx != CTRL_VALUE);
				end
			end
			PH_CHECKED: begin
				if (read_busy) begin
					nxt.tick_count = tick_inc;
					if (dp) begin
						nxt.got_reply = 1'b1;
						if (is_diag) begin
							if (rx != CTRL_VALUE) begin
								nxt.fault = 1'b1;
							end
							nxt.diag_count = '0;
							nxt.in_read    = 1'b0;
						end else begin
							nxt.diag_count = cur.diag_count + 1'b1;
							nxt.axis_pos   = (axis_inc >= AXIS_LIMIT) ? '0 : axis_inc;
						end
					end
					if (window_end) begin
						nxt.tick_count = '0;
						nxt.in_read    = 1'b0;
						if (!(cur.got_reply || dp)) begin
							nxt.fault = 1'b1;
						end
					end
				end else if (running) begin
					nxt.got_reply  = 1'b0;
					nxt.tick_count = (cur.diag_count == '0) ? tick_inc
						: TICK_W'(1);
					nxt.in_read    = 1'b1;
				end
			end
			default: begin
				nxt.phase = PH_IDLE;
			end
		endcase
	end

	// Result item
	always_comb begin
		result                 = '0;
		result.spi_start       = launch;
		result.cs_release      = consume;
		result.error_flag      = nxt.fault;
		result.ready_res       = (nxt.phase == PH_CHECKED);
		if (cur.phase == PH_IDLE) begin
			result.spi_first_byte  = CTRL_ADDR;
			result.spi_second_byte = CTRL_VALUE;
		end else if (launch) begin
			result.spi_second_byte = NO_BYTE;
			if (cur.phase == PH_WRITE_SENT || is_diag) begin
				result.spi_first_byte = READ_BIT | CTRL_ADDR;
			end else begin
				result.spi_first_byte = READ_BIT | axis_addr(cur.axis_pos);
			end
		end
		if (read_busy && dp && !is_diag) begin
			result.sample_valid = 1'b1;
			result.sample_axis  = cur.axis_pos;
			result.sample_value = rx;
		end
	end

endmodule

@@ hdl/aspi_checker.sv @@
// Port-level checks for the poll sequencer, bound to its top level.
// Depends on aspi_pkg and accel_spi_poll_sequencer.
module aspi_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input aspi_pkg::result_t result
);
	import aspi_pkg::*;

	logic err_seen_q;
	logic rdy_seen_q;

	// Track sticky flags already delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
			rdy_seen_q <= 1'b0;
		end else if (result_valid && result_ready) begin
			err_seen_q <= err_seen_q | result.error_flag;
			rdy_seen_q <= rdy_seen_q | result.ready_res;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result item dropped or changed while stalled");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && err_seen_q |-> result.error_flag)
		else $error("error flag cleared after being reported");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && rdy_seen_q |-> result.ready_res)
		else $error("bring-up done flag cleared after being reported");

	a_sample_consumes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sample_valid |->
			result.cs_release && result.ready_res && (result.sample_axis != AXIS_UNUSED))
		else $error("sample delivered without a consumed completion");

	a_idle_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.spi_start |->
			(result.spi_first_byte == NO_BYTE) && (result.spi_second_byte == NO_BYTE))
		else $error("command bytes present with no transfer launched");

endmodule

bind accel_spi_poll_sequencer aspi_checker u_aspi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

@@ dv/accel_spi_poll_sequencer_tb.sv @@
// Testbench for the accelerometer SPI poll sequencer: drives handler ticks that answer
// the transfers the block launches, predicts every result item and checks it field by field.
// Depends on aspi_pkg and the accel_spi_poll_sequencer top level.
module accel_spi_poll_sequencer_tb;
	import aspi_pkg::*;

	localparam logic [APB_AW-1:0] TIMEOUT_ADDR = APB_AW'(4 * REG_TIMEOUT);

class poll_scoreboard;
	// Predicted sequencer state
	logic [TICK_W-1:0] timeout;
	phase_t            phase;
	logic              fault;
	logic              in_read;
	logic              got_reply;
	logic [DIAG_W-1:0] diag;
	logic [AXIS_W-1:0] axis;
	logic [TICK_W-1:0] ticks;
	logic              done_pending;
	logic [7:0]        rx_hold;
	logic [7:0]        axis_reg [4];

	result_t results_due [$];
	int      errors;
	int      n_ticks;
	int      n_samples;
	int      n_rechecks;

	function new();
		timeout      = TIMEOUT_RST;
		phase        = PH_IDLE;
		fault        = 1'b0;
		in_read      = 1'b0;
		got_reply    = 1'b0;
		diag         = '0;
		axis         = '0;
		ticks        = '0;
		done_pending = 1'b0;
		rx_hold      = '0;
		axis_reg     = '{8'h29, 8'h2b, 8'h2d, 8'h29};
		errors       = 0;
		n_ticks      = 0;
		n_samples    = 0;
		n_rechecks   = 0;
	endfunction

	// Advance the predicted sequencer by one accepted tick and queue its result
	function void note_tick(tick_t t);
		result_t r;
		int      nxt;
		r = '0;
		n_ticks++;
		// latch a completion before the tick is processed
		if (t.spi_done) begin
			done_pending = 1'b1;
			rx_hold      = t.rx_byte;
		end
		if (phase != PH_CHECKED) begin
			unique case (phase)
				PH_IDLE: begin
					r.spi_start       = 1'b1;
					r.spi_first_byte  = CTRL_ADDR;
					r.spi_second_byte = CTRL_VALUE;
					phase             = PH_WRITE_SENT;
				end
				PH_WRITE_SENT: begin
					if (done_pending) begin
						done_pending     = 1'b0;
						r.cs_release     = 1'b1;
						r.spi_start      = 1'b1;
						r.spi_first_byte = READ_BIT | CTRL_ADDR;
						phase            = PH_READBACK_SENT;
					end
				end
				default: begin
					if (done_pending) begin
						done_pending = 1'b0;
						r.cs_release = 1'b1;
						fault        = (rx_hold != CTRL_VALUE);
						phase        = PH_CHECKED;
					end
				end
			endcase
		end else if (!fault) begin
			if (in_read) begin
				if (ticks != TICK_MAX)
					ticks++;
				if (done_pending) begin
					done_pending = 1'b0;
					r.cs_release = 1'b1;
					got_reply    = 1'b1;
					if (diag == DIAG_LAST) begin
						// control register recheck ends the read early
						if (rx_hold != CTRL_VALUE)
							fault = 1'b1;
						diag    = '0;
						in_read = 1'b0;
					end else begin
						r.sample_valid = 1'b1;
						r.sample_axis  = axis;
						r.sample_value = rx_hold;
						n_samples++;
						diag = diag + 1'b1;
						nxt  = (int'(axis) + 1) % 4;
						if (nxt >= NUM_AXES)
							nxt = 0;
						axis = AXIS_W'(nxt);
					end
				end
				// close the window, fault if it saw no reply
				if (ticks >= timeout) begin
					ticks   = '0;
					in_read = 1'b0;
					if (!got_reply)
						fault = 1'b1;
				end
			end else begin
				got_reply = 1'b0;
				if (diag == '0) begin
					if (ticks != TICK_MAX)
						ticks++;
				end else begin
					ticks = TICK_W'(1);
				end
				r.spi_start = 1'b1;
				if (diag == DIAG_LAST) begin
					r.spi_first_byte = READ_BIT | CTRL_ADDR;
					n_rechecks++;
				end else begin
					r.spi_first_byte = READ_BIT | axis_reg[axis];
				end
				in_read = 1'b1;
			end
		end
		r.error_flag = fault;
		r.ready_res  = (phase == PH_CHECKED);
		results_due.push_back(r);
	endfunction

	function void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// Compare one accepted result with the oldest prediction
	function void check_result(result_t got);
		result_t want;
		if (results_due.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none actual %h", $time, got);
			return;
		end
		want = results_due.pop_front();
		compare_field("spi_start", 8'(want.spi_start), 8'(got.spi_start));
		compare_field("spi_first_byte", want.spi_first_byte, got.spi_first_byte);
		compare_field("spi_second_byte", want.spi_second_byte, got.spi_second_byte);
		compare_field("cs_release", 8'(want.cs_release), 8'(got.cs_release));
		compare_field("sample_valid", 8'(want.sample_valid), 8'(got.sample_valid));
		compare_field("sample_axis", 8'(want.sample_axis), 8'(got.sample_axis));
		compare_field("sample_value", want.sample_value, got.sample_value);
		compare_field("error_flag", 8'(want.error_flag), 8'(got.error_flag));
		compare_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
	endfunction
endclass

	logic              clk;
	logic              arst_n;
	logic              tick_valid;
	logic              tick_ready;
	tick_t             tick;
	logic              result_valid;
	logic              result_ready;
	result_t           result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	poll_scoreboard sb = new();
	bit             send_burst = 1'b0;
	bit             recv_burst = 1'b0;
	int             n_settings = 0;

	accel_spi_poll_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.tick         (tick),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up well past the slowest correct run
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_valid && tick_ready)
				sb.note_tick(tick);
			if (result_valid && result_ready)
				sb.check_result(result);
		end
	end

	// Stall the result side at random, with bursts of no stall
	initial begin
		int gap;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 49) == 0)
				recv_burst = !recv_burst;
			gap = recv_burst ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
			@(negedge clk);
		end
	end

	function automatic tick_t mk_tick(logic done, logic [7:0] rx);
		tick_t t;
		t.spi_done = done;
		t.rx_byte  = rx;
		return t;
	endfunction

	// Pick the next tick from the predicted state: answer reads before the window
	// runs out, add stray completions now and then, keep control replies correct
	function automatic tick_t next_poll_tick();
		logic       done;
		logic [7:0] rx;
		rx = 8'($urandom_range(0, 255));
		if (sb.phase != PH_CHECKED)
			done = ($urandom_range(0, 3) == 0);
		else if (sb.in_read && !sb.got_reply)
			done = (int'(sb.ticks) + 1 >= int'(sb.timeout)) || ($urandom_range(0, 5) == 0);
		else
			done = ($urandom_range(0, 19) == 0);
		if (done && (sb.phase == PH_READBACK_SENT ||
			(sb.phase == PH_CHECKED && sb.diag == DIAG_LAST)))
			rx = CTRL_VALUE;
		return mk_tick(done, rx);
	endfunction

	// Offer one tick after a random gap and hold it until accepted
	task automatic drive_tick(tick_t t);
		int gap;
		if ($urandom_range(0, 49) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			tick_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_valid <= 1'b1;
		tick       <= t;
		do @(posedge clk); while (!(tick_valid && tick_ready));
		@(negedge clk);
	endtask

	// Hold the sender until every predicted result has come back
	task automatic drain();
		tick_valid <= 1'b0;
		while (sb.results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write the read window length, then read it back
	task automatic set_timeout(logic [TICK_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TIMEOUT_ADDR;
		pwdata  <= {16'($urandom_range(0, 65535)), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.timeout = value;
		n_settings++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {16'h0, value}) begin
			sb.errors++;
			$display("%0t: timeout_period readback, expected %0h actual %0h",
				$time, {16'h0, value}, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [TICK_W-1:0] to;
		int                n;
		arst_n     = 1'b0;
		tick_valid = 1'b0;
		tick       = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Bring-up with the reset window: a completion latched before the
		// write goes out, a correct readback, then a read and a stray completion
		drive_tick(mk_tick(1'b1, 8'hFF));
		drive_tick(mk_tick(1'b0, 8'h00));
		drive_tick(mk_tick(1'b0, 8'hA5));
		drive_tick(mk_tick(1'b1, CTRL_VALUE));
		drive_tick(mk_tick(1'b0, 8'h00));
		drive_tick(mk_tick(1'b1, 8'h00));
		drive_tick(mk_tick(1'b1, 8'hFF));
		drive_tick(mk_tick(1'b0, 8'h5A));
		repeat (12) drive_tick(next_poll_tick());

		// Random polling across window settings, extremes first
		for (int p = 0; p < 10; p++) begin
			unique case (p)
				0: begin to = 16'd1; n = 300; end
				1: begin to = 16'hFFFF; n = 150; end
				2: begin to = 16'd2; n = 200; end
				9: begin to = TIMEOUT_RST; n = 100; end
				default: begin to = 16'($urandom_range(3, 40)); n = 200; end
			endcase
			drain();
			set_timeout(to);
			repeat (n) drive_tick(next_poll_tick());
		end

		// Answer a control recheck with the wrong byte, then stay halted
		drain();
		set_timeout(16'd4);
		while (!sb.fault && !(sb.phase == PH_CHECKED && sb.in_read && !sb.got_reply &&
			sb.diag == DIAG_LAST))
			drive_tick(next_poll_tick());
		drive_tick(mk_tick(1'b1, 8'h46));
		drive_tick(mk_tick(1'b1, 8'hFF));
		drive_tick(mk_tick(1'b0, 8'h00));
		drive_tick(mk_tick(1'b1, 8'h00));
		drive_tick(mk_tick(1'b0, 8'hFF));

		// Wait out the last results and the pipeline behind them
		tick_valid <= 1'b0;
		while (sb.results_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Run covered %0d ticks, %0d axis samples and %0d control rechecks",
			sb.n_ticks, sb.n_samples, sb.n_rechecks);
		$display("over %0d window settings, ending in a halted sequencer", n_settings);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

@@ sim.f @@
hdl/aspi_pkg.sv
hdl/aspi_step.sv
hdl/accel_spi_poll_sequencer.sv
hdl/aspi_checker.sv
dv/accel_spi_poll_sequencer_tb.sv
